// ----- rtl/core/dec_pkg.sv -----
// Shared types and constants for the disc collision pipeline.
package dec_pkg;

  // Word widths of the interface fields.
  localparam int unsigned WordW  = 32;
  localparam int unsigned RadW   = 31;

  // The square root of a 64-bit radicand has 32 bits.
  localparam int unsigned RootW  = 32;

  // The unit normal and the mass weights are fractions with 30 bits below the point.
  localparam int unsigned NormSh = 30;
  localparam int unsigned QuoW   = NormSh + 1;
  localparam logic [QuoW-1:0] UnitN = QuoW'(1) << NormSh;

  // Lanes of the divider bank.
  localparam int unsigned LaneNx   = 0;
  localparam int unsigned LaneNy   = 1;
  localparam int unsigned LaneWa   = 2;
  localparam int unsigned LaneWb   = 3;
  localparam int unsigned NumLanes = 4;

  typedef logic signed [WordW-1:0] word_t;

  // Both discs' centers and velocities.
  typedef struct packed {
    word_t a_pos_x;
    word_t a_pos_y;
    word_t a_vel_x;
    word_t a_vel_y;
    word_t b_pos_x;
    word_t b_pos_y;
    word_t b_vel_x;
    word_t b_vel_y;
  } discs_t;

  // Context that rides along the square root stages.
  typedef struct packed {
    discs_t           discs;
    logic             hit;
    logic             dx_neg;
    logic             dy_neg;
    logic [RootW-1:0] adx;
    logic [RootW-1:0] ady;
    logic [RootW-1:0] rsum;
    logic [RadW-1:0]  ra;
    logic [RadW-1:0]  rb;
  } sq_side_t;

  // Context that rides along the divider stages.
  typedef struct packed {
    discs_t           discs;
    logic             hit;
    logic             dx_neg;
    logic             dy_neg;
    logic             d_zero;
    logic [RootW-1:0] ovl;
  } dv_side_t;

endpackage

// ----- rtl/core/disc_elastic_collision_top.sv -----
// Channel  Handshake                   Word
// -------  --------------------------  ---------------------------------------------
// input    in_valid_i / in_ready_o     two discs: centers, velocities, radii (Q16.16)
// output   out_valid_o / out_ready_i   resolved discs, saturated, and contact flag
//
// One word is taken every cycle unless a result waits at the output.
// The stages are the front stages, the 32-stage square root, the 31-stage divider bank and the resolve stages.
// Reset clears only the valid bits; no word is in flight after reset.
// When a result waits at the output, the whole pipeline holds and in_ready_o is low.
// Empty stages move on whenever the output register is free or being read.
module disc_elastic_collision_top
  import dec_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] a_pos_x_i,
  input  logic signed [31:0] a_pos_y_i,
  input  logic signed [31:0] a_vel_x_i,
  input  logic signed [31:0] a_vel_y_i,
  input  logic        [30:0] a_radius_i,
  input  logic signed [31:0] b_pos_x_i,
  input  logic signed [31:0] b_pos_y_i,
  input  logic signed [31:0] b_vel_x_i,
  input  logic signed [31:0] b_vel_y_i,
  input  logic        [30:0] b_radius_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] new_a_pos_x_o,
  output logic signed [31:0] new_a_pos_y_o,
  output logic signed [31:0] new_a_vel_x_o,
  output logic signed [31:0] new_a_vel_y_o,
  output logic signed [31:0] new_b_pos_x_o,
  output logic signed [31:0] new_b_pos_y_o,
  output logic signed [31:0] new_b_vel_x_o,
  output logic signed [31:0] new_b_vel_y_o,
  output logic               contact_o
);

  logic adv;

  // Front stage 1: center offsets and radius sum.
  logic               v1_q;
  discs_t             disc1_q;
  logic signed [32:0] dx1_q, dy1_q;
  logic [RadW-1:0]    ra1_q, rb1_q;
  logic [RootW-1:0]   rs1_q;

  // Front stage 2: offset magnitudes.
  logic               v2_q;
  discs_t             disc2_q;
  logic [32:0]        adx2_q, ady2_q;
  logic               dxn2_q, dyn2_q;
  logic [RadW-1:0]    ra2_q, rb2_q;
  logic [RootW-1:0]   rs2_q;

  // Front stage 3: squares and the bounding-box test.
  logic               v3_q;
  discs_t             disc3_q;
  logic [63:0]        sqx3_q, sqy3_q, rsq3_q;
  logic               pre3_q;
  logic [RootW-1:0]   adx3_q, ady3_q;
  logic               dxn3_q, dyn3_q;
  logic [RadW-1:0]    ra3_q, rb3_q;
  logic [RootW-1:0]   rs3_q;

  // Front stage 4: squared distance and the overlap decision.
  logic               v4_q;
  sq_side_t           side4_q;
  logic [63:0]        rad4_q;
  logic [64:0]        dsq;

  assign dsq = {1'b0, sqx3_q} + {1'b0, sqy3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      disc1_q <= '{a_pos_x: a_pos_x_i, a_pos_y: a_pos_y_i, a_vel_x: a_vel_x_i,
                   a_vel_y: a_vel_y_i, b_pos_x: b_pos_x_i, b_pos_y: b_pos_y_i,
                   b_vel_x: b_vel_x_i, b_vel_y: b_vel_y_i};
      dx1_q   <= 33'(b_pos_x_i) - 33'(a_pos_x_i);
      dy1_q   <= 33'(b_pos_y_i) - 33'(a_pos_y_i);
      ra1_q   <= a_radius_i;
      rb1_q   <= b_radius_i;
      rs1_q   <= {1'b0, a_radius_i} + {1'b0, b_radius_i};

      disc2_q <= disc1_q;
      adx2_q  <= dx1_q[32] ? 33'(-dx1_q) : 33'(dx1_q);
      ady2_q  <= dy1_q[32] ? 33'(-dy1_q) : 33'(dy1_q);
      dxn2_q  <= dx1_q[32];
      dyn2_q  <= dy1_q[32];
      ra2_q   <= ra1_q;
      rb2_q   <= rb1_q;
      rs2_q   <= rs1_q;

      disc3_q <= disc2_q;
      sqx3_q  <= adx2_q[31:0] * adx2_q[31:0];
      sqy3_q  <= ady2_q[31:0] * ady2_q[31:0];
      rsq3_q  <= rs2_q * rs2_q;
      pre3_q  <= (rs2_q != '0) && (adx2_q < {1'b0, rs2_q}) && (ady2_q < {1'b0, rs2_q});
      adx3_q  <= adx2_q[31:0];
      ady3_q  <= ady2_q[31:0];
      dxn3_q  <= dxn2_q;
      dyn3_q  <= dyn2_q;
      ra3_q   <= ra2_q;
      rb3_q   <= rb2_q;
      rs3_q   <= rs2_q;

      side4_q.discs  <= disc3_q;
      side4_q.hit    <= pre3_q && (dsq < {1'b0, rsq3_q});
      side4_q.dx_neg <= dxn3_q;
      side4_q.dy_neg <= dyn3_q;
      side4_q.adx    <= adx3_q;
      side4_q.ady    <= ady3_q;
      side4_q.rsum   <= rs3_q;
      side4_q.ra     <= ra3_q;
      side4_q.rb     <= rb3_q;
      rad4_q         <= dsq[63:0];
    end
  end

  // Center distance.
  logic             sq_valid;
  logic [RootW-1:0] sq_root;
  sq_side_t         sq_side;
  sq_side_t         sq_side_out;

  dec_isqrt #(
    .side_t (sq_side_t)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4_q),
    .rad_i   (rad4_q),
    .side_i  (sq_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side_out)
  );

  assign sq_side = side4_q;

  // Divider bank: normal components over the distance, radii over the radius sum.
  logic [NumLanes-1:0][RootW-1:0] dv_rem0, dv_den;
  logic [NumLanes-1:0][QuoW-1:0]  dv_low, dv_quo;
  dv_side_t                       dv_side_in, dv_side_out;
  logic                           dv_valid;

  always_comb begin
    dv_rem0[LaneNx] = {1'b0, sq_side_out.adx[RootW-1:1]};
    dv_low[LaneNx]  = {sq_side_out.adx[0], {NormSh{1'b0}}};
    dv_den[LaneNx]  = sq_root;
    dv_rem0[LaneNy] = {1'b0, sq_side_out.ady[RootW-1:1]};
    dv_low[LaneNy]  = {sq_side_out.ady[0], {NormSh{1'b0}}};
    dv_den[LaneNy]  = sq_root;
    dv_rem0[LaneWa] = {2'b00, sq_side_out.rb[RadW-1:1]};
    dv_low[LaneWa]  = {sq_side_out.rb[0], {NormSh{1'b0}}};
    dv_den[LaneWa]  = sq_side_out.rsum;
    dv_rem0[LaneWb] = {2'b00, sq_side_out.ra[RadW-1:1]};
    dv_low[LaneWb]  = {sq_side_out.ra[0], {NormSh{1'b0}}};
    dv_den[LaneWb]  = sq_side_out.rsum;

    dv_side_in.discs  = sq_side_out.discs;
    dv_side_in.hit    = sq_side_out.hit;
    dv_side_in.dx_neg = sq_side_out.dx_neg;
    dv_side_in.dy_neg = sq_side_out.dy_neg;
    dv_side_in.d_zero = (sq_root == '0);
    dv_side_in.ovl    = sq_side_out.rsum - sq_root;
  end

  dec_div #(
    .Lanes  (NumLanes),
    .side_t (dv_side_t)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_valid),
    .rem0_i  (dv_rem0),
    .den_i   (dv_den),
    .low_i   (dv_low),
    .side_i  (dv_side_in),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side_out)
  );

  // Separation, velocity exchange and the output register.
  discs_t res_discs;

  dec_resolve u_resolve (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (dv_valid),
    .side_i    (dv_side_out),
    .quo_i     (dv_quo),
    .valid_o   (out_valid_o),
    .discs_o   (res_discs),
    .contact_o (contact_o)
  );

  // The pipeline moves whenever the output register is free or being read.
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  assign new_a_pos_x_o = res_discs.a_pos_x;
  assign new_a_pos_y_o = res_discs.a_pos_y;
  assign new_a_vel_x_o = res_discs.a_vel_x;
  assign new_a_vel_y_o = res_discs.a_vel_y;
  assign new_b_pos_x_o = res_discs.b_pos_x;
  assign new_b_pos_y_o = res_discs.b_pos_y;
  assign new_b_vel_x_o = res_discs.b_vel_x;
  assign new_b_vel_y_o = res_discs.b_vel_y;

  // An overlap is only flagged for discs with size whose offsets lie inside the radius sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && side4_q.hit |-> (side4_q.rsum != '0) && (side4_q.adx < side4_q.rsum) &&
                            (side4_q.ady < side4_q.rsum))
    else $error("overlap flagged outside the radius sum");

endmodule

// ----- rtl/core/dec_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module dec_isqrt
  import dec_pkg::*;
#(
  parameter type side_t = logic
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [2*RootW-1:0] rad_i,
  input  side_t              side_i,
  output logic               valid_o,
  output logic [RootW-1:0]   root_o,
  output side_t              side_o
);

  localparam int unsigned RemW = RootW + 2;

  typedef struct packed {
    logic [RemW-1:0]    rem;
    logic [RootW-1:0]   root;
    logic [2*RootW-1:0] rad;
  } step_t;

  logic  v_in  [RootW+1];
  logic  v_q   [RootW];
  step_t st_in [RootW+1];
  step_t st_q  [RootW];
  side_t sd_in [RootW+1];
  side_t sd_q  [RootW];

  assign v_in[0]  = valid_i;
  assign st_in[0] = {RemW'(0), RootW'(0), rad_i};
  assign sd_in[0] = side_i;

  for (genvar k = 0; k < RootW; k++) begin : g_step
    logic [RemW+1:0] cur;
    logic [RemW+1:0] trial;
    logic            take;
    step_t           nxt;

    // Bring down the next two radicand bits and try the next root bit.
    assign cur   = {st_in[k].rem, st_in[k].rad[2*RootW-1 -: 2]};
    assign trial = {2'b00, st_in[k].root, 2'b01};
    assign take  = (cur >= trial);

    always_comb begin
      nxt.rem  = take ? RemW'(cur - trial) : RemW'(cur);
      nxt.root = {st_in[k].root[RootW-2:0], take};
      nxt.rad  = {st_in[k].rad[2*RootW-3:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
        sd_q[k] <= sd_in[k];
      end
    end

    assign v_in[k+1]  = v_q[k];
    assign st_in[k+1] = st_q[k];
    assign sd_in[k+1] = sd_q[k];
  end

  assign valid_o = v_in[RootW];
  assign root_o  = st_in[RootW].root;
  assign side_o  = sd_in[RootW];

  // The remainder never exceeds twice the root, or the root is too small.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_in[RootW] |-> (st_in[RootW].rem <= RemW'({st_in[RootW].root, 1'b0})))
    else $error("square root remainder out of bound");

endmodule

// ----- rtl/core/dec_div.sv -----
// Bank of pipelined restoring dividers, one quotient bit per stage.
module dec_div
  import dec_pkg::*;
#(
  parameter int unsigned Lanes = 4,
  parameter type side_t = logic
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [Lanes-1:0][RootW-1:0] rem0_i,
  input  logic [Lanes-1:0][RootW-1:0] den_i,
  input  logic [Lanes-1:0][QuoW-1:0]  low_i,
  input  side_t                       side_i,
  output logic                        valid_o,
  output logic [Lanes-1:0][QuoW-1:0]  quo_o,
  output side_t                       side_o
);

  typedef struct packed {
    logic [RootW-1:0] rem;
    logic [RootW-1:0] den;
    logic [QuoW-1:0]  low;
    logic [QuoW-1:0]  quo;
  } lane_t;

  typedef lane_t [Lanes-1:0] row_t;

  logic  v_in  [QuoW+1];
  logic  v_q   [QuoW];
  row_t  st_in [QuoW+1];
  row_t  st_q  [QuoW];
  side_t sd_in [QuoW+1];
  side_t sd_q  [QuoW];

  assign v_in[0]  = valid_i;
  assign sd_in[0] = side_i;

  // The top part of the dividend enters as the first partial remainder.
  for (genvar l = 0; l < Lanes; l++) begin : g_load
    assign st_in[0][l] = {rem0_i[l], den_i[l], low_i[l], QuoW'(0)};
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    row_t nxt;

    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      logic [RootW:0]   cur;
      logic             take;
      logic [RootW-1:0] rem_n;

      assign cur   = {st_in[k][l].rem, st_in[k][l].low[QuoW-1]};
      assign take  = (cur >= {1'b0, st_in[k][l].den});
      assign rem_n = take ? RootW'(cur - {1'b0, st_in[k][l].den}) : RootW'(cur);
      assign nxt[l] = {rem_n, st_in[k][l].den,
                       {st_in[k][l].low[QuoW-2:0], 1'b0},
                       {st_in[k][l].quo[QuoW-2:0], take}};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
        sd_q[k] <= sd_in[k];
      end
    end

    assign v_in[k+1]  = v_q[k];
    assign st_in[k+1] = st_q[k];
    assign sd_in[k+1] = sd_q[k];
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_out
    assign quo_o[l] = st_in[QuoW][l].quo;
  end

  assign valid_o = v_in[QuoW];
  assign side_o  = sd_in[QuoW];

endmodule

// ----- rtl/core/dec_resolve.sv -----
// Separation and velocity exchange along the unit normal, with saturation.
module dec_resolve
  import dec_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  dv_side_t                       side_i,
  input  logic [NumLanes-1:0][QuoW-1:0]  quo_i,
  output logic                           valid_o,
  output discs_t                         discs_o,
  output logic                           contact_o
);

  localparam int unsigned Depth = 10;
  localparam int unsigned ProdW = 68;
  localparam word_t WordMax = {1'b0, {(WordW-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(WordW-1){1'b0}}};
  localparam word_t NMax    = word_t'({1'b0, UnitN});

  // Product shifted right, truncated toward zero.
  function automatic logic signed [ProdW-1:0] tz_shift(input logic signed [ProdW-1:0] p,
                                                       input int unsigned sh);
    logic signed [ProdW-1:0] bias;
    bias = p[ProdW-1] ? ((ProdW'(1) << sh) - ProdW'(1)) : ProdW'(0);
    return (p + bias) >>> sh;
  endfunction

  // Clamp to the signed word range.
  function automatic word_t sat_word(input logic signed [36:0] v);
    word_t r;
    if (v > 37'(WordMax)) begin
      r = WordMax;
    end else if (v < 37'(WordMin)) begin
      r = WordMin;
    end else begin
      r = WordW'(v);
    end
    return r;
  endfunction

  logic   v_q   [Depth];
  logic   hit_q [Depth];
  discs_t disc_q [Depth];
  discs_t disc_d [Depth];

  word_t             nx_q [7];
  word_t             ny_q [7];
  logic [QuoW-1:0]   wa_q [5];
  logic [QuoW-1:0]   wb_q [5];
  logic [RootW-1:0]  ov_q;

  logic signed [64:0] psx_q, psy_q;
  logic signed [63:0] pax_q, pay_q, pbx_q, pby_q;
  logic signed [32:0] sxo_q, syo_q, tax_q, tay_q, tbx_q, tby_q;
  logic signed [33:0] ua_q, ub_q, npax_q, npay_q, npbx_q, npby_q;
  logic signed [34:0] dab_q, dba_q;
  logic signed [66:0] pda_q, pdb_q;
  logic signed [35:0] da_q, db_q;
  logic signed [67:0] qax_q, qay_q, qbx_q, qby_q;
  logic signed [35:0] dvax_q, dvay_q, dvbx_q, dvby_q;

  logic [QuoW-1:0] nx_mag, ny_mag;
  word_t           nx_d, ny_d;

  // Signed unit normal; coincident centers use the x axis.
  always_comb begin
    nx_mag = side_i.d_zero ? UnitN : quo_i[LaneNx];
    ny_mag = side_i.d_zero ? QuoW'(0) : quo_i[LaneNy];
    nx_d   = side_i.dx_neg ? -word_t'({1'b0, nx_mag}) : word_t'({1'b0, nx_mag});
    ny_d   = side_i.dy_neg ? -word_t'({1'b0, ny_mag}) : word_t'({1'b0, ny_mag});
  end

  // Disc words move down the pipe; positions and velocities are replaced on contact.
  always_comb begin
    disc_d[0] = side_i.discs;
    for (int k = 1; k < Depth; k++) begin
      disc_d[k] = disc_q[k-1];
    end
    if (hit_q[3]) begin
      disc_d[4].a_pos_x = sat_word(37'(npax_q));
      disc_d[4].a_pos_y = sat_word(37'(npay_q));
      disc_d[4].b_pos_x = sat_word(37'(npbx_q));
      disc_d[4].b_pos_y = sat_word(37'(npby_q));
    end
    if (hit_q[8]) begin
      disc_d[9].a_vel_x = sat_word(37'(disc_q[8].a_vel_x) + 37'(dvax_q));
      disc_d[9].a_vel_y = sat_word(37'(disc_q[8].a_vel_y) + 37'(dvay_q));
      disc_d[9].b_vel_x = sat_word(37'(disc_q[8].b_vel_x) + 37'(dvbx_q));
      disc_d[9].b_vel_y = sat_word(37'(disc_q[8].b_vel_y) + 37'(dvby_q));
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Depth; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < Depth; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  // Data path stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      disc_q   <= disc_d;
      hit_q[0] <= side_i.hit;
      for (int k = 1; k < Depth; k++) begin
        hit_q[k] <= hit_q[k-1];
      end

      // Stage 0: normal, weights and overlap.
      nx_q[0] <= nx_d;
      ny_q[0] <= ny_d;
      wa_q[0] <= quo_i[LaneWa];
      wb_q[0] <= quo_i[LaneWb];
      ov_q    <= side_i.ovl;
      for (int k = 1; k < 7; k++) begin
        nx_q[k] <= nx_q[k-1];
        ny_q[k] <= ny_q[k-1];
      end
      for (int k = 1; k < 5; k++) begin
        wa_q[k] <= wa_q[k-1];
        wb_q[k] <= wb_q[k-1];
      end

      // Stage 1: overlap and velocity projections onto the normal.
      psx_q <= $signed({1'b0, ov_q}) * nx_q[0];
      psy_q <= $signed({1'b0, ov_q}) * ny_q[0];
      pax_q <= disc_q[0].a_vel_x * nx_q[0];
      pay_q <= disc_q[0].a_vel_y * ny_q[0];
      pbx_q <= disc_q[0].b_vel_x * nx_q[0];
      pby_q <= disc_q[0].b_vel_y * ny_q[0];

      // Stage 2: scale the products back down.
      sxo_q <= 33'(tz_shift(ProdW'(psx_q), NormSh + 1));
      syo_q <= 33'(tz_shift(ProdW'(psy_q), NormSh + 1));
      tax_q <= 33'(tz_shift(ProdW'(pax_q), NormSh));
      tay_q <= 33'(tz_shift(ProdW'(pay_q), NormSh));
      tbx_q <= 33'(tz_shift(ProdW'(pbx_q), NormSh));
      tby_q <= 33'(tz_shift(ProdW'(pby_q), NormSh));

      // Stage 3: normal speeds and separated centers.
      ua_q   <= 34'(tax_q) + 34'(tay_q);
      ub_q   <= 34'(tbx_q) + 34'(tby_q);
      npax_q <= 34'(disc_q[2].a_pos_x) - 34'(sxo_q);
      npay_q <= 34'(disc_q[2].a_pos_y) - 34'(syo_q);
      npbx_q <= 34'(disc_q[2].b_pos_x) + 34'(sxo_q);
      npby_q <= 34'(disc_q[2].b_pos_y) + 34'(syo_q);

      // Stage 4: relative normal speed.
      dab_q <= 35'(ub_q) - 35'(ua_q);
      dba_q <= 35'(ua_q) - 35'(ub_q);

      // Stage 5: weight by the other disc's share of the mass.
      pda_q <= dab_q * $signed({1'b0, wa_q[4]});
      pdb_q <= dba_q * $signed({1'b0, wb_q[4]});

      // Stage 6: twice the weighted change.
      da_q <= 36'(tz_shift(ProdW'(pda_q), NormSh - 1));
      db_q <= 36'(tz_shift(ProdW'(pdb_q), NormSh - 1));

      // Stage 7: project the change back onto x and y.
      qax_q <= da_q * nx_q[6];
      qay_q <= da_q * ny_q[6];
      qbx_q <= db_q * nx_q[6];
      qby_q <= db_q * ny_q[6];

      // Stage 8: scale back down; stage 9 adds and saturates.
      dvax_q <= 36'(tz_shift(qax_q, NormSh));
      dvay_q <= 36'(tz_shift(qay_q, NormSh));
      dvbx_q <= 36'(tz_shift(qbx_q, NormSh));
      dvby_q <= 36'(tz_shift(qby_q, NormSh));
    end
  end

  assign valid_o   = v_q[Depth-1];
  assign discs_o   = disc_q[Depth-1];
  assign contact_o = hit_q[Depth-1];

  // No component of a contact normal is larger than one in magnitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && hit_q[0] |-> (nx_q[0] <= NMax) && (nx_q[0] >= -NMax) &&
                           (ny_q[0] <= NMax) && (ny_q[0] >= -NMax))
    else $error("unit normal out of range");

  // The two mass weights add up to one, less at most one unit of rounding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && hit_q[0] |-> (({1'b0, wa_q[0]} + {1'b0, wb_q[0]}) <= {1'b0, UnitN}) &&
                           (({1'b0, wa_q[0]} + {1'b0, wb_q[0]}) >= ({1'b0, UnitN} - 32'd1)))
    else $error("mass weights do not sum to one");

endmodule
